### rtl/rwlt_pkg.sv
// Shared types and codes for the reader/writer lock table.
package rwlt_pkg;

  localparam int unsigned OwnerW  = 4;
  localparam int unsigned InKeyW  = 32;
  localparam int unsigned HeldW   = 6;

  typedef enum logic [1:0] {
    FUNC_LOCK_SH  = 2'd0,
    FUNC_LOCK_EX  = 2'd1,
    FUNC_UNLOCK   = 2'd2,
    FUNC_UNLOCK_ALL = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_INVALID  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [OwnerW-1:0] owner;
    logic [InKeyW-1:0] lock_key;
  } req_t;

  typedef struct packed {
    logic             granted;
    logic [1:0]       status;
    logic             key_locked;
    logic [HeldW-1:0] owner_held;
  } rsp_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic look;
    logic lock_sh;
    logic lock_ex;
    logic alloc_en;
    logic unlock;
    logic unlock_all;
  } cell_cmd_t;

endpackage

### rtl/rwlt_cell.sv
// One lock entry of the table: key, writer and reader mask, plus chain links.
module rwlt_cell import rwlt_pkg::*; #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned NUM_OWNERS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_cmd_t             cmd_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [OwnerW-1:0]     owner_i,
  input  logic [NUM_OWNERS-1:0] bit_i,
  input  logic                  free_i,
  output logic                  free_o,
  input  logic [OwnerW-1:0]     writer_i,
  output logic [OwnerW-1:0]     writer_o,
  input  logic [NUM_OWNERS-1:0] readers_i,
  output logic [NUM_OWNERS-1:0] readers_o,
  input  logic                  match_i,
  output logic                  match_o,
  output logic                  hit_o
);

  logic                  valid_q, valid_d;
  logic                  hit_q, alloc_q;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [OwnerW-1:0]     writer_q, writer_d;
  logic [NUM_OWNERS-1:0] readers_q, readers_d;
  logic                  match_now, holds, apply_lock, release_en;
  logic [OwnerW-1:0]     base_w, rel_w;
  logic [NUM_OWNERS-1:0] base_r, rel_r;

  assign match_now = valid_q && (key_q == key_i);
  assign match_o   = match_i | match_now;
  assign free_o    = free_i | ~valid_q;
  assign writer_o  = writer_i | (hit_q ? writer_q : '0);
  assign readers_o = readers_i | (hit_q ? readers_q : '0);
  assign hit_o     = hit_q;

  assign holds      = (writer_q == owner_i) || (|(readers_q & bit_i));
  assign apply_lock = (cmd_i.lock_sh | cmd_i.lock_ex) &
                      (hit_q | (alloc_q & cmd_i.alloc_en));
  assign release_en = valid_q & ((cmd_i.unlock & hit_q & holds) | cmd_i.unlock_all);

  always_comb begin
    base_w    = hit_q ? writer_q : '0;
    base_r    = hit_q ? readers_q : '0;
    rel_w     = (writer_q == owner_i) ? '0 : writer_q;
    rel_r     = readers_q & ~bit_i;
    valid_d   = valid_q;
    key_d     = key_q;
    writer_d  = writer_q;
    readers_d = readers_q;
    if (apply_lock) begin
      valid_d   = 1'b1;
      key_d     = key_i;
      writer_d  = cmd_i.lock_ex ? owner_i : base_w;
      readers_d = cmd_i.lock_sh ? (base_r | bit_i) : (base_r & ~bit_i);
    end else if (release_en) begin
      writer_d  = rel_w;
      readers_d = rel_r;
      valid_d   = (rel_w != '0) || (rel_r != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
      alloc_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.look) begin
        hit_q   <= match_now;
        alloc_q <= ~valid_q & ~free_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    writer_q  <= writer_d;
    readers_q <= readers_d;
  end

endmodule

### rtl/reader_writer_lock_table.sv
// An accepted request passes through the lookup, update and result states before its
// result beat is presented.
// The next request is taken only once the result register is loaded; the result state
// waits while an earlier beat is still stalled in the output register.
// A result beat waits in the output register while the next request is accepted.
// Reset clears all entry valid bits and per-owner held counts at once; no sweep.
module reader_writer_lock_table import rwlt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned NUM_OWNERS    = 16,
  parameter int unsigned KEY_BITS      = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  localparam int unsigned OwnIdxW = $clog2(NUM_OWNERS);
  localparam int unsigned CntW    = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_UPD  = 4'b0100,
    S_RES  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  req_t   req_q;
  logic   out_valid_q;
  rsp_t   out_q;
  logic   granted_q;
  logic [1:0] status_q;

  logic [CntW-1:0] held_q [NUM_OWNERS];

  logic [KEY_BITS-1:0]   key_int;
  logic                  own_ok, arg_bad;
  logic [OwnIdxW-1:0]    own_idx;
  logic [NUM_OWNERS-1:0] own_bit;
  cell_cmd_t             cmd;

  logic [TABLE_ENTRIES:0]  free_c, match_c;
  logic [OwnerW-1:0]       writer_c  [TABLE_ENTRIES+1];
  logic [NUM_OWNERS-1:0]   readers_c [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] hit_vec;

  logic any_hit, any_free, conflict, had, grant, is_lock;
  logic [OwnerW-1:0]     hit_w;
  logic [NUM_OWNERS-1:0] hit_r;
  logic [CntW-1:0]       held_cur;

  always_comb begin
    for (int b = 0; b < KEY_BITS; b++) begin
      key_int[b] = (b < InKeyW) ? req_q.lock_key[b] : 1'b0;
    end
  end

  assign own_ok  = (req_q.owner != '0) && ({28'd0, req_q.owner} < NUM_OWNERS);
  assign own_idx = OwnIdxW'(req_q.owner);
  assign arg_bad = !own_ok || ((req_q.func != FUNC_UNLOCK_ALL) && (key_int == '0));
  assign is_lock = (req_q.func == FUNC_LOCK_SH) || (req_q.func == FUNC_LOCK_EX);

  always_comb begin
    for (int j = 0; j < NUM_OWNERS; j++) begin
      own_bit[j] = own_ok && (req_q.owner == OwnerW'(j));
    end
  end

  assign any_hit  = |hit_vec;
  assign any_free = free_c[TABLE_ENTRIES];
  assign hit_w    = writer_c[TABLE_ENTRIES];
  assign hit_r    = readers_c[TABLE_ENTRIES];
  assign held_cur = held_q[own_idx];

  assign conflict = any_hit && (((hit_w != '0) && (hit_w != req_q.owner)) ||
                    ((req_q.func == FUNC_LOCK_EX) && (hit_r != '0) && (hit_r != own_bit)));
  assign had      = any_hit && ((hit_w == req_q.owner) || (|(hit_r & own_bit)));
  assign grant    = (state_q == S_UPD) && !arg_bad && is_lock && !conflict &&
                    (any_hit || any_free);

  always_comb begin
    cmd            = '0;
    cmd.look       = (state_q == S_LOOK);
    cmd.lock_sh    = grant && (req_q.func == FUNC_LOCK_SH);
    cmd.lock_ex    = grant && (req_q.func == FUNC_LOCK_EX);
    cmd.alloc_en   = grant && !any_hit;
    cmd.unlock     = (state_q == S_UPD) && !arg_bad && (req_q.func == FUNC_UNLOCK);
    cmd.unlock_all = (state_q == S_UPD) && !arg_bad && (req_q.func == FUNC_UNLOCK_ALL);
  end

  assign free_c[0]    = 1'b0;
  assign match_c[0]   = 1'b0;
  assign writer_c[0]  = '0;
  assign readers_c[0] = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    rwlt_cell #(
      .KEY_BITS  (KEY_BITS),
      .NUM_OWNERS(NUM_OWNERS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .key_i    (key_int),
      .owner_i  (req_q.owner),
      .bit_i    (own_bit),
      .free_i   (free_c[g]),
      .free_o   (free_c[g+1]),
      .writer_i (writer_c[g]),
      .writer_o (writer_c[g+1]),
      .readers_i(readers_c[g]),
      .readers_o(readers_c[g+1]),
      .match_i  (match_c[g]),
      .match_o  (match_c[g+1]),
      .hit_o    (hit_vec[g])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_LOOK;
      S_LOOK: state_d = S_UPD;
      S_UPD:  state_d = S_RES;
      S_RES:  if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int j = 0; j < NUM_OWNERS; j++) held_q[j] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_UPD && own_ok) begin
        // count keys per owner
        if (grant && !had) begin
          held_q[own_idx] <= held_cur + CntW'(1);
        end else if (cmd.unlock && any_hit && had && held_cur != '0) begin
          held_q[own_idx] <= held_cur - CntW'(1);
        end else if (cmd.unlock_all) begin
          held_q[own_idx] <= '0;
        end
      end
      if (state_q == S_RES && state_d == S_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) req_q <= in_data_i;
    if (state_q == S_UPD) begin
      granted_q <= grant;
      if (arg_bad) status_q <= ST_INVALID;
      else if (is_lock && conflict) status_q <= ST_CONFLICT;
      else if (is_lock && !any_hit && !any_free) status_q <= ST_FULL;
      else status_q <= ST_OK;
    end
    if (state_q == S_RES && state_d == S_IDLE) begin
      out_q.granted    <= granted_q;
      out_q.status     <= status_q;
      out_q.key_locked <= match_c[TABLE_ENTRIES];
      out_q.owner_held <= own_ok ? HeldW'(held_cur) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_LOOK))
    else $error("accepted beat did not start lookup");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> $onehot0(hit_vec))
    else $error("key held by more than one entry");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RES && out_valid_o && out_stall_i) |=> (state_q == S_RES))
    else $error("result overwrote a stalled beat");
`endif

endmodule
